// ===== hw/rtl/efms_pkg.sv =====
// shared constants and helpers for the earliest-free-machine scheduler
`default_nettype none

package efms_pkg;

	// default machine capacity of the finish-time heap
	localparam int unsigned MAX_MACHINES_DEF = 64;

	// field widths
	localparam int unsigned MC_W   = 7;
	localparam int unsigned IN_W   = 31;
	localparam int unsigned TIME_W = 32;

	// begin + duration, saturating at the top of the time range
	function automatic logic [TIME_W-1:0] sat_add(
		input logic [TIME_W-1:0] a,
		input logic [IN_W-1:0]   b
	);
		logic [TIME_W:0] sum;
		sum = {1'b0, a} + {2'b00, b};
		sat_add = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/efms_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module efms_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/earliest_free_machine_scheduler_top.sv =====
// top level of the earliest-free-machine list scheduler
`default_nettype none

// Each task accepted on start (while busy is low) is given to the machine that
// frees earliest. Busy finish times live in a binary min-heap in one ram with a
// single read and a single write port; a small sequencer walks it one level at
// a time. A task that fills a free machine returns its result from S_ADD and
// then sifts up through S_UP and S_UP_CMP at each heap level; a task that
// reuses a machine reads the root in S_ROOT, returns its result from S_ADD and
// then sifts down through S_DN, S_DN_L and S_DN_R at each level (left child,
// right child, move). busy stays high until the sift ends, so a new task is
// taken only once the last one is through. The result strobe result_valid is
// high for exactly one cycle and cannot be held off, so the receiver must take
// every beat as it comes.
// machine_count may be written at any time; it is sampled when a task starts.
module earliest_free_machine_scheduler_top #(
	parameter int unsigned MAX_MACHINES = efms_pkg::MAX_MACHINES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration channel
	input  wire logic                        cfg_valid,
	output      logic                        cfg_ready,
	input  wire logic [efms_pkg::MC_W-1:0]   machine_count,
	// task command
	input  wire logic                        start,
	output      logic                        busy,
	input  wire logic                        new_batch,
	input  wire logic [efms_pkg::IN_W-1:0]   task_ready,
	input  wire logic [efms_pkg::IN_W-1:0]   task_duration,
	// result beat
	output      logic                        result_valid,
	output      logic [efms_pkg::TIME_W-1:0] task_begin,
	output      logic [efms_pkg::TIME_W-1:0] task_finish,
	output      logic [efms_pkg::TIME_W-1:0] makespan
);

	localparam int unsigned IDX_W = $clog2(MAX_MACHINES);
	localparam int unsigned CNT_W = $clog2(MAX_MACHINES + 1);
	localparam int unsigned CW    = IDX_W + 2;
	localparam int unsigned LIM_W = (CNT_W > efms_pkg::MC_W) ? CNT_W : efms_pkg::MC_W;
	localparam int unsigned TW    = efms_pkg::TIME_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ROOT,
		S_ADD,
		S_UP,
		S_UP_CMP,
		S_DN,
		S_DN_L,
		S_DN_R
	} state_t;

	state_t state_q;

	logic [efms_pkg::MC_W-1:0]  mc_q;
	logic [CNT_W-1:0]           size_q;
	logic [IDX_W-1:0]           pos_q;
	logic [TW-1:0]              val_q;
	logic [TW-1:0]              best_val_q;
	logic [IDX_W-1:0]           best_idx_q;
	logic                       best_child_q;
	logic                       push_q;
	logic [efms_pkg::IN_W-1:0]  ready_q;
	logic [efms_pkg::IN_W-1:0]  dur_q;
	logic [TW-1:0]              begin_q;
	logic [TW-1:0]              finish_q;
	logic [TW-1:0]              mk_q;
	logic                       valid_q;

	logic                       ram_we;
	logic [IDX_W-1:0]           ram_waddr;
	logic [TW-1:0]              ram_wdata;
	logic [IDX_W-1:0]           ram_raddr;
	logic [TW-1:0]              ram_rdata;

	logic [LIM_W-1:0]           mc_ext;
	logic [LIM_W-1:0]           limit;
	logic [CNT_W-1:0]           eff_size;
	logic                       do_push;
	logic [CW-1:0]              left_c;
	logic [CW-1:0]              right_c;
	logic [CW-1:0]              size_c;
	logic [IDX_W-1:0]           parent;
	logic                       has_left;
	logic                       has_right;
	logic                       l_lt_v;
	logic                       r_lt_best;
	logic [TW-1:0]              ready_ext;
	logic [TW-1:0]              fin;

	// effective machine count: zero means one, capped at capacity
	always_comb begin
		mc_ext = LIM_W'(mc_q);
		if (mc_q == '0) begin
			limit = LIM_W'(1);
		end else if (mc_ext > LIM_W'(MAX_MACHINES)) begin
			limit = LIM_W'(MAX_MACHINES);
		end else begin
			limit = mc_ext;
		end
	end

	assign eff_size = new_batch ? '0 : size_q;
	assign do_push  = LIM_W'(eff_size) < limit;

	// heap index arithmetic
	assign left_c    = CW'({pos_q, 1'b1});
	assign right_c   = left_c + CW'(1);
	assign size_c    = CW'(size_q);
	assign parent    = (pos_q - IDX_W'(1)) >> 1;
	assign has_left  = left_c < size_c;
	assign has_right = right_c < size_c;
	assign l_lt_v    = ram_rdata < val_q;
	assign r_lt_best = ram_rdata < best_val_q;

	// start time is the later of the earliest free finish and the ready time
	assign ready_ext = TW'(ready_q);
	assign fin       = efms_pkg::sat_add(begin_q, dur_q);

	// ram port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = val_q;
		ram_raddr = '0;
		case (state_q)
			S_UP: begin
				if (pos_q == '0) begin
					ram_we = 1'b1;
				end else begin
					ram_raddr = parent;
				end
			end
			S_UP_CMP: begin
				ram_we = 1'b1;
				if (val_q < ram_rdata) begin
					ram_wdata = ram_rdata;
				end
			end
			S_DN: begin
				if (!has_left) begin
					ram_we = 1'b1;
				end else begin
					ram_raddr = left_c[IDX_W-1:0];
				end
			end
			S_DN_L: begin
				if (!has_right) begin
					ram_we = 1'b1;
					if (l_lt_v) begin
						ram_wdata = ram_rdata;
					end
				end else begin
					ram_raddr = right_c[IDX_W-1:0];
				end
			end
			S_DN_R: begin
				ram_we    = 1'b1;
				ram_wdata = r_lt_best ? ram_rdata : best_val_q;
			end
			default: begin
				ram_raddr = '0;
			end
		endcase
	end

	// finish-time heap storage
	efms_ram #(
		.WIDTH (TW),
		.DEPTH (MAX_MACHINES)
	) u_heap (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// sequencer, heap bookkeeping and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mc_q         <= efms_pkg::MC_W'(1);
			size_q       <= '0;
			mk_q         <= '0;
			valid_q      <= 1'b0;
			pos_q        <= '0;
			val_q        <= '0;
			best_val_q   <= '0;
			best_idx_q   <= '0;
			best_child_q <= 1'b0;
			push_q       <= 1'b0;
			ready_q      <= '0;
			dur_q        <= '0;
			begin_q      <= '0;
			finish_q     <= '0;
		end else begin
			valid_q <= 1'b0;
			if (cfg_valid) begin
				mc_q <= machine_count;
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						ready_q <= task_ready;
						dur_q   <= task_duration;
						size_q  <= eff_size;
						push_q  <= do_push;
						begin_q <= TW'(task_ready);
						if (new_batch) begin
							mk_q <= '0;
						end
						state_q <= do_push ? S_ADD : S_ROOT;
					end
				end
				S_ROOT: begin
					if (ram_rdata > ready_ext) begin
						begin_q <= ram_rdata;
					end
					state_q <= S_ADD;
				end
				S_ADD: begin
					finish_q <= fin;
					valid_q  <= 1'b1;
					val_q    <= fin;
					if (fin > mk_q) begin
						mk_q <= fin;
					end
					if (push_q) begin
						pos_q   <= size_q[IDX_W-1:0];
						size_q  <= size_q + CNT_W'(1);
						state_q <= S_UP;
					end else begin
						pos_q   <= '0;
						state_q <= S_DN;
					end
				end
				S_UP: begin
					state_q <= (pos_q == '0) ? S_IDLE : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (val_q < ram_rdata) begin
						pos_q   <= parent;
						state_q <= S_UP;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_DN: begin
					state_q <= has_left ? S_DN_L : S_IDLE;
				end
				S_DN_L: begin
					if (!has_right) begin
						if (l_lt_v) begin
							pos_q   <= left_c[IDX_W-1:0];
							state_q <= S_DN;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						best_val_q   <= l_lt_v ? ram_rdata : val_q;
						best_idx_q   <= left_c[IDX_W-1:0];
						best_child_q <= l_lt_v;
						state_q      <= S_DN_R;
					end
				end
				S_DN_R: begin
					if (r_lt_best) begin
						pos_q   <= right_c[IDX_W-1:0];
						state_q <= S_DN;
					end else if (best_child_q) begin
						pos_q   <= best_idx_q;
						state_q <= S_DN;
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// port drive
	assign cfg_ready    = 1'b1;
	assign busy         = state_q != S_IDLE;
	assign result_valid = valid_q;
	assign task_begin   = begin_q;
	assign task_finish  = finish_q;
	assign makespan     = mk_q;

endmodule

`default_nettype wire

// ===== tb/sv/earliest_free_machine_scheduler_top_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the earliest-free-machine scheduler top level
module earliest_free_machine_scheduler_top_tb;
	import efms_pkg::*;

	localparam int unsigned CAPACITY      = MAX_MACHINES_DEF;
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned SETTLE_CYCLES = 30;

	typedef struct packed {
		logic [TIME_W-1:0] t_begin;
		logic [TIME_W-1:0] t_finish;
		logic [TIME_W-1:0] t_span;
	} slot_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [MC_W-1:0]   machine_count;
	logic              start;
	logic              busy;
	logic              new_batch;
	logic [IN_W-1:0]   task_ready;
	logic [IN_W-1:0]   task_duration;
	logic              result_valid;
	logic [TIME_W-1:0] task_begin;
	logic [TIME_W-1:0] task_finish;
	logic [TIME_W-1:0] makespan;

	// predicted schedule state
	logic [TIME_W-1:0] free_at [CAPACITY];
	int unsigned       busy_cnt;
	logic [TIME_W-1:0] span_now;
	logic [MC_W-1:0]   count_reg;

	slot_t       sched_slots [$];
	int unsigned err_cnt   = 0;
	int unsigned cycle_cnt = 0;
	bit          gaps_on   = 1'b1;

	earliest_free_machine_scheduler_top #(
		.MAX_MACHINES(CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.machine_count(machine_count),
		.start(start),
		.busy(busy),
		.new_batch(new_batch),
		.task_ready(task_ready),
		.task_duration(task_duration),
		.result_valid(result_valid),
		.task_begin(task_begin),
		.task_finish(task_finish),
		.makespan(makespan)
	);

	// 20 ns clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run guard
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("earliest_free_machine_scheduler_top regression: fail");
			$finish;
		end
	end

	task automatic flag_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		err_cnt++;
	endtask

	// place one task on the earliest free machine and return its slot
	function automatic slot_t schedule_task(input bit nb, input logic [IN_W-1:0] rdy,
			input logic [IN_W-1:0] dur);
		slot_t             s;
		int unsigned       lim;
		int unsigned       pos;
		int unsigned       par;
		int unsigned       lc;
		int unsigned       rc;
		int unsigned       best;
		logic [TIME_W-1:0] st;
		logic [TIME_W-1:0] fin;
		logic [TIME_W-1:0] tmp;
		logic [TIME_W:0]   sum;
		if (nb) begin
			busy_cnt = 0;
			span_now = '0;
		end
		lim = count_reg;
		if (lim == 0)
			lim = 1;
		if (lim > CAPACITY)
			lim = CAPACITY;
		if (busy_cnt < lim)
			st = {1'b0, rdy};
		else
			st = (free_at[0] > {1'b0, rdy}) ? free_at[0] : {1'b0, rdy};
		sum = {1'b0, st} + {2'b00, dur};
		fin = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
		if (busy_cnt < lim) begin
			// free machine: append and sift up
			pos = busy_cnt;
			busy_cnt++;
			free_at[pos] = fin;
			while (pos > 0) begin
				par = (pos - 1) / 2;
				if (free_at[pos] >= free_at[par])
					break;
				tmp = free_at[pos];
				free_at[pos] = free_at[par];
				free_at[par] = tmp;
				pos = par;
			end
		end else begin
			// reuse the earliest machine: overwrite the root and sift down
			free_at[0] = fin;
			pos = 0;
			forever begin
				lc = 2 * pos + 1;
				rc = lc + 1;
				best = pos;
				if (lc < busy_cnt && free_at[lc] < free_at[best])
					best = lc;
				if (rc < busy_cnt && free_at[rc] < free_at[best])
					best = rc;
				if (best == pos)
					break;
				tmp = free_at[pos];
				free_at[pos] = free_at[best];
				free_at[best] = tmp;
				pos = best;
			end
		end
		if (fin > span_now)
			span_now = fin;
		s.t_begin = st;
		s.t_finish = fin;
		s.t_span = span_now;
		return s;
	endfunction

	// one task beat, with an optional gap in front
	task automatic issue_task(input bit nb, input logic [IN_W-1:0] rdy,
			input logic [IN_W-1:0] dur);
		int unsigned gap;
		if (gaps_on && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 3);
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		new_batch <= nb;
		task_ready <= rdy;
		task_duration <= dur;
		do @(posedge clk); while (busy !== 1'b0);
		sched_slots.push_back(schedule_task(nb, rdy, dur));
	endtask

	// stop issuing and wait for the block to go quiet
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (sched_slots.size() != 0) @(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
	endtask

	// configuration beat, only issued while idle
	task automatic set_machine_count(input logic [MC_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		machine_count <= value;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		count_reg = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// result checker: every strobe pairs with the oldest predicted slot
	always @(posedge clk) begin
		slot_t want;
		if (arst_n && result_valid === 1'b1) begin
			if (sched_slots.size() == 0) begin
				flag_mismatch($sformatf("unexpected result begin %0h finish %0h",
					task_begin, task_finish));
			end else begin
				want = sched_slots.pop_front();
				if (task_begin !== want.t_begin)
					flag_mismatch($sformatf("task_begin %0h, expected %0h",
						task_begin, want.t_begin));
				if (task_finish !== want.t_finish)
					flag_mismatch($sformatf("task_finish %0h, expected %0h",
						task_finish, want.t_finish));
				if (makespan !== want.t_span)
					flag_mismatch($sformatf("makespan %0h, expected %0h",
						makespan, want.t_span));
			end
		end
	end

	// reset count of one machine, field extremes and finish saturation
	task automatic test_reset_count_saturation();
		issue_task(1'b0, '0, '0);
		issue_task(1'b0, '1, '1);
		issue_task(1'b0, '0, 31'd1);
		issue_task(1'b0, 31'd5, '1);
		settle();
	endtask

	// new batch clears the machines and the makespan
	task automatic test_new_batch();
		issue_task(1'b1, 31'd10, 31'd5);
		issue_task(1'b0, 31'd3, 31'd2);
		settle();
	endtask

	// a count of zero behaves as one machine
	task automatic test_zero_count();
		set_machine_count('0);
		issue_task(1'b1, 31'd100, 31'd10);
		issue_task(1'b0, 31'd50, 31'd20);
		settle();
	endtask

	// a count beyond capacity is clipped
	task automatic test_above_capacity();
		set_machine_count('1);
		issue_task(1'b1, 31'd0, 31'd3);
		issue_task(1'b0, 31'd1, 31'd4);
		issue_task(1'b0, 31'd2, 31'd5);
		settle();
	endtask

	// lowering the count mid-batch keeps every busy machine in play
	task automatic test_count_lowered();
		set_machine_count(7'd4);
		issue_task(1'b1, 31'd0, 31'd40);
		issue_task(1'b0, 31'd0, 31'd10);
		issue_task(1'b0, 31'd0, 31'd30);
		issue_task(1'b0, 31'd0, 31'd20);
		settle();
		set_machine_count(7'd2);
		issue_task(1'b0, 31'd0, 31'd5);
		issue_task(1'b0, 31'd0, 31'd5);
		issue_task(1'b0, 31'd0, 31'd5);
		settle();
	endtask

	// one phase of random batches under a given count
	task automatic run_phase(input logic [MC_W-1:0] cnt, input int unsigned n_items,
			input bit allow_gaps);
		int unsigned       lim;
		int unsigned       base;
		int unsigned       pick;
		bit                nb;
		logic [IN_W-1:0]   rdy;
		logic [IN_W-1:0]   dur;
		set_machine_count(cnt);
		lim = (cnt == 0) ? 1 : ((cnt > CAPACITY) ? CAPACITY : cnt);
		base = $urandom_range(0, 1000);
		gaps_on = allow_gaps;
		for (int unsigned i = 0; i < n_items; i++) begin
			// batches mostly longer than the machine count
			if (i == 0)
				nb = $urandom_range(0, 1);
			else
				nb = ($urandom_range(0, 4 * lim + 8) == 0);
			if (nb)
				base = $urandom_range(0, 1000);
			if (allow_gaps && i % 40 == 0)
				gaps_on = ($urandom_range(0, 2) != 0);
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				rdy = IN_W'($urandom);
			end else begin
				rdy = IN_W'(base + $urandom_range(0, 60));
				base += $urandom_range(0, 25);
			end
			pick = $urandom_range(0, 19);
			case (pick)
				0: dur = IN_W'($urandom);
				1: dur = '0;
				2: dur = '1 - IN_W'($urandom_range(0, 3));
				default: dur = IN_W'($urandom_range(1, 250));
			endcase
			issue_task(nb, rdy, dur);
		end
		settle();
	endtask

	// random batches across small, full and out-of-range counts
	task automatic test_random_batches();
		run_phase(7'd64, 75, 1'b1);
		run_phase(7'd127, 75, 1'b1);
		run_phase(7'd0, 75, 1'b1);
		run_phase(7'd65, 75, 1'b1);
		run_phase(7'd1, 75, 1'b1);
		for (int unsigned k = 0; k < 4; k++)
			run_phase(MC_W'($urandom_range(1, 64)), 75, 1'b1);
	endtask

	// closing stretch with tasks offered back to back
	task automatic test_back_to_back();
		run_phase(MC_W'($urandom_range(2, 16)), 75, 1'b0);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		machine_count = '0;
		start = 1'b0;
		new_batch = 1'b0;
		task_ready = '0;
		task_duration = '0;
		for (int unsigned k = 0; k < CAPACITY; k++)
			free_at[k] = '0;
		busy_cnt = 0;
		span_now = '0;
		count_reg = 7'd1;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_count_saturation();
		test_new_batch();
		test_zero_count();
		test_above_capacity();
		test_count_lowered();
		test_random_batches();
		test_back_to_back();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sched_slots.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", sched_slots.size()));
		if (err_cnt == 0)
			$display("earliest_free_machine_scheduler_top regression: pass");
		else
			$display("earliest_free_machine_scheduler_top regression: fail");
		$finish;
	end

endmodule

// ===== earliest_free_machine_scheduler_top.f =====
hw/rtl/efms_pkg.sv
hw/rtl/efms_ram.sv
hw/rtl/earliest_free_machine_scheduler_top.sv
tb/sv/earliest_free_machine_scheduler_top_tb.sv
